// File: hdl/dbmmc_pkg.sv
// Package for the debounced brushed motor mode controller.
// Holds the payload word types, mode codes and duty scaling constants.
// No dependencies.
package dbmmc_pkg;

  // Input word opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // Mode codes as reported in the result word.
  localparam logic [1:0] MODE_REST  = 2'd0;
  localparam logic [1:0] MODE_DRIVE = 2'd1;
  localparam logic [1:0] MODE_DECAY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [1:0] REG_FRAME_ID   = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd2;

  localparam logic [15:0] PWM_PERIOD_RST = 16'd2399;
  localparam logic [10:0] FRAME_ID_RST   = 11'd3;
  localparam logic [7:0]  DEBOUNCE_RST   = 8'd50;

  // Speed saturation and duty scaling: duty = min(speed, 25) * period * 8 / 250.
  // The product speed * period * 4 is below 2^23 and is divided by 125 with a
  // reciprocal multiply: ceil(2^30 / 125), exact for every value below 2^30 / 51.
  localparam logic [7:0]  SPEED_CAP  = 8'd25;
  localparam int          SCALED_W   = 23;
  localparam logic [23:0] DUTY_RECIP = 24'd8589935;
  localparam int          RECIP_SHIFT = 30;
  localparam int          RECIP_PROD_W = SCALED_W + 24;

  typedef enum logic [2:0] {
    ST_REST  = 3'b001,
    ST_DRIVE = 3'b010,
    ST_DECAY = 3'b100
  } mode_state_e;

  typedef struct packed {
    logic        opcode;
    logic [10:0] frame_id;
    logic [7:0]  frame_first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        high_side_on;
    logic        low_side_on;
    logic [15:0] duty_compare;
  } out_item_t;

endpackage

// File: hdl/debounced_brushed_motor_mode_control.sv
// Top level of the debounced brushed motor mode controller.
// Depends on dbmmc_pkg for payload types, mode codes and duty constants.
//
// The block accepts one word per clock cycle while in_ready_o is high. A frame
// word whose identifier matches frame_id_q replaces the held speed and
// produces no result. A tick word produces one result: switch drives and PWM
// compare for the mode the tick starts in, after which the debounce counters
// advance and may change the mode. Words pass through three registers: the
// input register, where the mode and speed state are updated in order, a
// product register holding speed * period * 4, and the result register,
// filled after a reciprocal multiply by 1/125. Backpressure on the result side
// stalls the pipeline, while frames keep being absorbed as long as the input
// register can drain.
module debounced_brushed_motor_mode_control (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dbmmc_pkg::in_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dbmmc_pkg::out_item_t out_item_o
);

  // Configuration registers.
  logic [15:0] pwm_period_q;
  logic [10:0] frame_id_q;
  logic [7:0]  debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_period_q <= dbmmc_pkg::PWM_PERIOD_RST;
      frame_id_q   <= dbmmc_pkg::FRAME_ID_RST;
      debounce_q   <= dbmmc_pkg::DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dbmmc_pkg::REG_PWM_PERIOD: pwm_period_q <= cfg_wdata_i;
        dbmmc_pkg::REG_FRAME_ID:   frame_id_q   <= cfg_wdata_i[10:0];
        dbmmc_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic                a_valid_q;
  dbmmc_pkg::in_item_t a_item_q;
  logic                b_valid_q;
  logic                a_adv;
  logic                b_free;
  logic                b_adv;
  logic                c_free;
  logic                a_is_tick;

  assign c_free     = !out_valid_o || out_ready_i;
  assign b_adv      = b_valid_q && c_free;
  assign b_free     = !b_valid_q || c_free;
  assign a_is_tick  = (a_item_q.opcode == dbmmc_pkg::OP_TICK);
  assign a_adv      = a_valid_q && (!a_is_tick || b_free);
  assign in_ready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_item_q <= in_item_i;
    end
  end

  // Mode and speed state, updated as each word leaves the input register.
  dbmmc_pkg::mode_state_e mode_q, mode_d;
  logic [7:0] speed_q, speed_d;
  logic [7:0] r2d_cnt_q, r2d_cnt_d;
  logic [7:0] d2s_cnt_q, d2s_cnt_d;
  logic [7:0] s2d_cnt_q, s2d_cnt_d;
  logic [7:0] s2r_cnt_q, s2r_cnt_d;

  logic [1:0]  res_mode;
  logic        res_hs;
  logic        res_ls;
  logic [4:0]  speed_sat;
  logic [20:0] speed_period;
  logic [dbmmc_pkg::SCALED_W-1:0] scaled;
  logic        speed_zero;

  assign speed_zero   = (speed_q == 8'd0);
  assign speed_sat    = (speed_q > dbmmc_pkg::SPEED_CAP) ? dbmmc_pkg::SPEED_CAP[4:0]
                                                         : speed_q[4:0];
  assign speed_period = 21'(speed_sat) * 21'(pwm_period_q);

  always_comb begin
    mode_d    = mode_q;
    speed_d   = speed_q;
    r2d_cnt_d = r2d_cnt_q;
    d2s_cnt_d = d2s_cnt_q;
    s2d_cnt_d = s2d_cnt_q;
    s2r_cnt_d = s2r_cnt_q;
    res_mode  = dbmmc_pkg::MODE_REST;
    res_hs    = 1'b0;
    res_ls    = 1'b0;
    scaled    = '0;

    if (!a_is_tick) begin
      if (a_item_q.frame_id == frame_id_q) begin
        speed_d = a_item_q.frame_first_byte;
      end
    end else begin
      unique case (mode_q)
        dbmmc_pkg::ST_DRIVE: begin
          res_mode = dbmmc_pkg::MODE_DRIVE;
          res_hs   = 1'b1;
          res_ls   = 1'b1;
          scaled   = {speed_period, 2'b00};
          d2s_cnt_d = speed_zero ? d2s_cnt_q + 8'd1 : 8'd0;
          if (d2s_cnt_d > debounce_q) begin
            mode_d    = dbmmc_pkg::ST_DECAY;
            d2s_cnt_d = 8'd0;
          end
        end
        dbmmc_pkg::ST_DECAY: begin
          res_mode = dbmmc_pkg::MODE_DECAY;
          res_ls   = 1'b1;
          if (speed_zero) begin
            s2d_cnt_d = 8'd0;
            s2r_cnt_d = s2r_cnt_q + 8'd1;
          end else begin
            s2r_cnt_d = 8'd0;
            s2d_cnt_d = s2d_cnt_q + 8'd1;
          end
          // The return to drive takes precedence over the return to rest.
          if (s2d_cnt_d > debounce_q) begin
            s2d_cnt_d = 8'd0;
            s2r_cnt_d = 8'd0;
            mode_d    = dbmmc_pkg::ST_DRIVE;
          end else if (s2r_cnt_d > debounce_q) begin
            s2d_cnt_d = 8'd0;
            s2r_cnt_d = 8'd0;
            mode_d    = dbmmc_pkg::ST_REST;
          end
        end
        default: begin
          r2d_cnt_d = speed_zero ? 8'd0 : r2d_cnt_q + 8'd1;
          if (r2d_cnt_d > debounce_q) begin
            mode_d    = dbmmc_pkg::ST_DRIVE;
            r2d_cnt_d = 8'd0;
          end else begin
            mode_d = dbmmc_pkg::ST_REST;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dbmmc_pkg::ST_REST;
      speed_q   <= 8'd0;
      r2d_cnt_q <= 8'd0;
      d2s_cnt_q <= 8'd0;
      s2d_cnt_q <= 8'd0;
      s2r_cnt_q <= 8'd0;
    end else if (a_adv) begin
      mode_q    <= mode_d;
      speed_q   <= speed_d;
      r2d_cnt_q <= r2d_cnt_d;
      d2s_cnt_q <= d2s_cnt_d;
      s2d_cnt_q <= s2d_cnt_d;
      s2r_cnt_q <= s2r_cnt_d;
    end
  end

  // Product stage.
  logic [1:0]  b_mode_q;
  logic        b_hs_q;
  logic        b_ls_q;
  logic [dbmmc_pkg::SCALED_W-1:0] b_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_free) begin
      b_valid_q <= a_adv && a_is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_free && a_adv && a_is_tick) begin
      b_mode_q   <= res_mode;
      b_hs_q     <= res_hs;
      b_ls_q     <= res_ls;
      b_scaled_q <= scaled;
    end
  end

  // Divide by 125 through the reciprocal.
  logic [dbmmc_pkg::RECIP_PROD_W-1:0] recip_prod;

  assign recip_prod = dbmmc_pkg::RECIP_PROD_W'(b_scaled_q)
                    * dbmmc_pkg::RECIP_PROD_W'(dbmmc_pkg::DUTY_RECIP);

  // Result register.
  logic                 out_valid_q;
  dbmmc_pkg::out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_free) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_item_q.mode         <= b_mode_q;
      out_item_q.high_side_on <= b_hs_q;
      out_item_q.low_side_on  <= b_ls_q;
      out_item_q.duty_compare <= recip_prod[dbmmc_pkg::RECIP_SHIFT +: 16];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for debounced_brushed_motor_mode_control.
// Depends on dbmmc_pkg and the top module; it predicts every tick result
// in place and checks it against the result channel.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DUTY_NUM    = 8;
  localparam int unsigned DUTY_DEN    = 250;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int          IDLE_PCT    = 34;
  localparam int          PIPE_CYCLES = 8;
  localparam int          CYCLE_LIMIT = 400000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [1:0]           cfg_idx_i   = dbmmc_pkg::REG_PWM_PERIOD;
  logic [15:0]          cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  dbmmc_pkg::in_item_t  in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  dbmmc_pkg::out_item_t out_item_o;

  debounced_brushed_motor_mode_control u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Words waiting to be driven and switch results waiting to be seen.
  dbmmc_pkg::in_item_t  pending_words[$];
  dbmmc_pkg::out_item_t switch_outputs_q[$];

  // Motor controller state as the design should hold it.
  logic [15:0] period_cfg   = dbmmc_pkg::PWM_PERIOD_RST;
  logic [10:0] frame_id_cfg = dbmmc_pkg::FRAME_ID_RST;
  logic [7:0]  limit_cfg    = dbmmc_pkg::DEBOUNCE_RST;
  logic [1:0]  cur_mode     = dbmmc_pkg::MODE_REST;
  logic [7:0]  held_speed   = '0;
  logic [7:0]  rest_drive_cnt  = '0;
  logic [7:0]  drive_decay_cnt = '0;
  logic [7:0]  decay_drive_cnt = '0;
  logic [7:0]  decay_rest_cnt  = '0;

  int  mismatches = 0;
  int  cycles     = 0;
  bit  no_gaps    = 1'b0;
  bit  in_fired   = 1'b0;

  task automatic advance_motor_model(input dbmmc_pkg::in_item_t w);
    dbmmc_pkg::out_item_t res;
    int unsigned          capped;
    if (w.opcode == dbmmc_pkg::OP_FRAME) begin
      if (w.frame_id == frame_id_cfg) begin
        held_speed = w.frame_first_byte;
      end
    end else begin
      res = '0;
      res.mode = cur_mode;
      case (cur_mode)
        dbmmc_pkg::MODE_DRIVE: begin
          res.high_side_on = 1'b1;
          res.low_side_on  = 1'b1;
          capped = (held_speed > dbmmc_pkg::SPEED_CAP) ? dbmmc_pkg::SPEED_CAP : held_speed;
          res.duty_compare = 16'((capped * period_cfg * DUTY_NUM) / DUTY_DEN);
          drive_decay_cnt = (held_speed == 0) ? drive_decay_cnt + 8'd1 : 8'd0;
          if (drive_decay_cnt > limit_cfg) begin
            cur_mode = dbmmc_pkg::MODE_DECAY;
            drive_decay_cnt = '0;
          end
        end
        dbmmc_pkg::MODE_DECAY: begin
          res.low_side_on = 1'b1;
          if (held_speed == 0) begin
            decay_drive_cnt = '0;
            decay_rest_cnt  = decay_rest_cnt + 8'd1;
          end else begin
            decay_rest_cnt  = '0;
            decay_drive_cnt = decay_drive_cnt + 8'd1;
          end
          // The drive test wins when both could fire.
          if (decay_drive_cnt > limit_cfg) begin
            decay_drive_cnt = '0;
            decay_rest_cnt  = '0;
            cur_mode = dbmmc_pkg::MODE_DRIVE;
          end else if (decay_rest_cnt > limit_cfg) begin
            decay_drive_cnt = '0;
            decay_rest_cnt  = '0;
            cur_mode = dbmmc_pkg::MODE_REST;
          end
        end
        default: begin
          res.mode = dbmmc_pkg::MODE_REST;
          rest_drive_cnt = (held_speed != 0) ? rest_drive_cnt + 8'd1 : 8'd0;
          if (rest_drive_cnt > limit_cfg) begin
            cur_mode = dbmmc_pkg::MODE_DRIVE;
            rest_drive_cnt = '0;
          end else begin
            cur_mode = dbmmc_pkg::MODE_REST;
          end
        end
      endcase
      switch_outputs_q.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: a new word goes out once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fired)) begin
      if (pending_words.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_words.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: predict on every accepted input word, check every result word.
  always @(posedge clk_i) begin : monitor
    dbmmc_pkg::out_item_t want;
    if (rst_ni) begin
      in_fired <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        advance_motor_model(in_item_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (switch_outputs_q.size() == 0) begin
          $error("result word with no tick pending: %p", out_item_o);
          mismatches++;
        end else begin
          want = switch_outputs_q.pop_front();
          check_field("mode", 16'(want.mode), 16'(out_item_o.mode));
          check_field("high_side_on", 16'(want.high_side_on), 16'(out_item_o.high_side_on));
          check_field("low_side_on", 16'(want.low_side_on), 16'(out_item_o.low_side_on));
          check_field("duty_compare", want.duty_compare, out_item_o.duty_compare);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void push_frame(input logic [10:0] fid, input logic [7:0] speed);
    dbmmc_pkg::in_item_t w;
    w.opcode           = dbmmc_pkg::OP_FRAME;
    w.frame_id         = fid;
    w.frame_first_byte = speed;
    pending_words.push_back(w);
  endfunction

  function automatic void push_speed(input logic [7:0] speed);
    push_frame(frame_id_cfg, speed);
  endfunction

  // A frame that the block must ignore, since its identifier differs.
  function automatic void push_stray_frame();
    logic [10:0] fid;
    fid = 11'($urandom_range(2047));
    if (fid == frame_id_cfg) begin
      fid = fid ^ 11'h1;
    end
    push_frame(fid, 8'($urandom_range(255)));
  endfunction

  // Tick payload fields are don't-care, so they carry random bits.
  function automatic void push_tick();
    dbmmc_pkg::in_item_t w;
    w.opcode           = dbmmc_pkg::OP_TICK;
    w.frame_id         = 11'($urandom_range(2047));
    w.frame_first_byte = 8'($urandom_range(255));
    pending_words.push_back(w);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      dbmmc_pkg::REG_PWM_PERIOD: period_cfg   = val;
      dbmmc_pkg::REG_FRAME_ID:   frame_id_cfg = val[10:0];
      dbmmc_pkg::REG_DEBOUNCE:   limit_cfg    = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every word is in and every result is out, then lets the
  // pipeline empty of frames that produce nothing.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || in_valid_i || switch_outputs_q.size() != 0);
    repeat (PIPE_CYCLES) @(negedge clk_i);
  endtask

  // Random phase: speed commands followed by runs of ticks, some long enough to
  // cross the debounce limit, with ignored frames mixed in.
  task automatic run_phase(input logic [15:0] period, input logic [10:0] fid,
                           input logic [7:0] limit, input int n_words, input bit steady);
    int made;
    int run_len;
    logic [7:0] speed;
    settle();
    write_reg(dbmmc_pkg::REG_PWM_PERIOD, period);
    write_reg(dbmmc_pkg::REG_FRAME_ID, 16'(fid));
    write_reg(dbmmc_pkg::REG_DEBOUNCE, 16'(limit));
    no_gaps = steady;
    made = 0;
    while (made < n_words) begin
      if ($urandom_range(7) == 0) begin
        push_stray_frame();
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: speed = 8'd0;
          4, 5, 6:    speed = 8'($urandom_range(1, 25));
          7, 8:       speed = 8'($urandom_range(26, 255));
          default:    speed = 8'd255;
        endcase
        push_speed(speed);
        made++;
      end
      run_len = $urandom_range(1, int'(limit) + 5);
      repeat (run_len) begin
        if ($urandom_range(9) == 0) begin
          push_stray_frame();
        end
        push_tick();
        made++;
      end
    end
    settle();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero speed, speed above the cap, ignored identifiers.
    push_tick();
    push_speed(8'd255);
    push_tick();
    push_frame(11'd4, 8'd0);
    push_frame(11'h7FF, 8'd0);
    push_frame(11'd0, 8'd0);
    push_tick();
    push_speed(8'd0);
    push_tick();
    settle();

    // Writes to the unused index must leave every register alone.
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(dbmmc_pkg::REG_DEBOUNCE, 16'd0);
    // With no debounce every condition switches the mode on its first tick.
    push_speed(8'd255);
    push_tick();
    push_tick();
    push_speed(8'd0);
    push_tick();
    push_tick();
    push_tick();
    push_speed(8'd30);
    push_tick();
    push_tick();
    push_speed(8'd25);
    push_tick();
    push_speed(8'd0);
    push_tick();
    push_speed(8'd5);
    push_tick();
    push_tick();
    push_speed(8'd26);
    push_tick();

    run_phase(16'd0, 11'd0, 8'd0, 50, 1'b0);
    run_phase(16'hFFFF, 11'h7FF, 8'd1, 55, 1'b0);
    run_phase(16'd2399, 11'h555, 8'd2, 55, 1'b0);
    run_phase(16'hAAAA, 11'h2AA, 8'd3, 55, 1'b1);
    run_phase(16'($urandom_range(65535)), 11'($urandom_range(2047)),
              8'($urandom_range(6)), 50, 1'b0);
    run_phase(16'd1234, 11'd5, 8'd1, 40, 1'b0);

    // A limit of 255 can never be exceeded; the counters wrap instead.
    settle();
    write_reg(dbmmc_pkg::REG_DEBOUNCE, 16'd255);
    push_speed(8'd9);
    repeat (258) push_tick();
    settle();

    if (mismatches == 0 && switch_outputs_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
